// ----- rtl/core/resub_feasibility_check_macros.svh -----
// assertion macros shared by the resubstitution feasibility check rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef RESUB_FEASIBILITY_CHECK_MACROS_SVH
`define RESUB_FEASIBILITY_CHECK_MACROS_SVH

// same-cycle implication, disabled during reset
`define RFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rfc_pkg.sv -----
// types and constants for the resubstitution feasibility check
// no dependencies; compiled before the interfaces and modules
package rfc_pkg;

    localparam int FIELD_BITS      = 64;
    localparam int PATTERN_COUNT   = 16;
    localparam int DIVISOR_MAX     = 4;
    localparam int DIV_COUNT_BITS  = 3;

    localparam logic [DIV_COUNT_BITS-1:0] RESET_DIVISOR_COUNT = 3'd4;

    typedef logic [PATTERN_COUNT-1:0] t_pattern_mask;

    // per-word pattern occurrence, split by target value
    typedef struct packed {
        t_pattern_mask offset;
        t_pattern_mask onset;
    } t_seen;

endpackage

// ----- rtl/core/rfc_in_if.sv -----
// input channel: one truth-table word of target and four divisors per transaction
// depends on rfc_pkg
interface rfc_in_if;
    import rfc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] target_word;
    logic [FIELD_BITS-1:0] first_divisor_word;
    logic [FIELD_BITS-1:0] second_divisor_word;
    logic [FIELD_BITS-1:0] third_divisor_word;
    logic [FIELD_BITS-1:0] fourth_divisor_word;
    logic                  last_word;

    modport source (
        output valid, target_word, first_divisor_word, second_divisor_word,
               third_divisor_word, fourth_divisor_word, last_word,
        input  ready
    );

    modport sink (
        input  valid, target_word, first_divisor_word, second_divisor_word,
               third_divisor_word, fourth_divisor_word, last_word,
        output ready
    );

endinterface

// ----- rtl/core/rfc_out_if.sv -----
// result channel: feasibility flag and conflict pattern mask per transaction
// depends on rfc_pkg
interface rfc_out_if;
    import rfc_pkg::*;

    logic          valid;
    logic          ready;
    logic          feasible;
    t_pattern_mask conflict_patterns;

    modport source (
        output valid, feasible, conflict_patterns,
        input  ready
    );

    modport sink (
        input  valid, feasible, conflict_patterns,
        output ready
    );

endinterface

// ----- rtl/core/resub_feasibility_check.sv -----
// top level of the boolean resubstitution feasibility check
// depends on rfc_pkg, rfc_in_if, rfc_out_if, rfc_pattern_scan and the macro header

// Streams truth tables one word per input transaction: the target word and the
// same word of four divisors. For each of the 16 divisor value patterns two
// sticky bits record whether the pattern occurred with target 0 and with
// target 1. A transaction with last_word set produces one result transaction:
// conflict_patterns (bit h set when pattern h met both target values, bit b of
// h being the inverted value of divisor b) and feasible (no conflict); the
// sticky bits then clear for the next truth table. Words that are not last
// produce no result. divisor_count (0..4, reset 4, larger values act as 4)
// picks how many divisors take part; the rest are treated as all ones, so a
// count of zero checks that the target is constant. Only the low WORD_BITS
// bits of each word are examined. Throughput is one word per clock unless the
// input stalls: the word is registered, scanned by the pattern logic in the
// next cycle and folded into the sticky bits, with the result registered at
// the output behind the word register. Input ready drops only while a last
// word waits behind an output register holding a result that is not taken
// in that cycle. Write divisor_count only while no words are in flight.
`include "resub_feasibility_check_macros.svh"

module resub_feasibility_check #(
    parameter int WORD_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfc_pkg::DIV_COUNT_BITS-1:0]  i_cfg_wdata,
    rfc_in_if.sink                              i_in,
    rfc_out_if.source                           o_out
);
    import rfc_pkg::*;

    // configuration
    logic [DIV_COUNT_BITS-1:0] r_divisor_count;

    // word register stage
    logic                                  r_s1_valid;
    logic                                  r_s1_last;
    logic [WORD_BITS-1:0]                  r_s1_target;
    logic [DIVISOR_MAX-1:0][WORD_BITS-1:0] r_s1_divisor;

    // sticky pattern state
    t_pattern_mask r_offset_seen;
    t_pattern_mask r_onset_seen;
    t_pattern_mask n_offset_seen;
    t_pattern_mask n_onset_seen;

    // result register
    logic          r_out_valid;
    logic          r_feasible;
    t_pattern_mask r_conflict;
    logic          n_out_valid;

    t_seen         w_seen;
    t_pattern_mask w_offset_acc;
    t_pattern_mask w_onset_acc;
    t_pattern_mask w_conflict;
    logic          w_s1_go;
    logic          w_s1_fire;
    logic          w_in_fire;
    logic          w_out_fire;

    // handshake control
    // a non-last word always drains into the sticky bits; a last word needs
    // room in the result register
    assign w_out_fire = r_out_valid && o_out.ready;
    assign w_s1_go    = !r_s1_last || !r_out_valid || o_out.ready;
    assign w_s1_fire  = r_s1_valid && w_s1_go;
    assign i_in.ready = !r_s1_valid || w_s1_go;
    assign w_in_fire  = i_in.valid && i_in.ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor_count <= RESET_DIVISOR_COUNT;
        end else if (i_cfg_we) begin
            r_divisor_count <= i_cfg_wdata;
        end
    end

    // word register: control with reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_last       <= i_in.last_word;
            r_s1_target     <= i_in.target_word[WORD_BITS-1:0];
            r_s1_divisor[0] <= i_in.first_divisor_word[WORD_BITS-1:0];
            r_s1_divisor[1] <= i_in.second_divisor_word[WORD_BITS-1:0];
            r_s1_divisor[2] <= i_in.third_divisor_word[WORD_BITS-1:0];
            r_s1_divisor[3] <= i_in.fourth_divisor_word[WORD_BITS-1:0];
        end
    end

    // pattern scan of the registered word
    rfc_pattern_scan #(
        .WORD_BITS (WORD_BITS)
    ) u_scan (
        .i_target        (r_s1_target),
        .i_divisor       (r_s1_divisor),
        .i_divisor_count (r_divisor_count),
        .o_seen          (w_seen)
    );

    // fold the word into the sticky bits; the last word clears them
    assign w_offset_acc = r_offset_seen | w_seen.offset;
    assign w_onset_acc  = r_onset_seen | w_seen.onset;
    assign w_conflict   = w_offset_acc & w_onset_acc;

    always_comb begin
        n_offset_seen = r_offset_seen;
        n_onset_seen  = r_onset_seen;
        if (w_s1_fire) begin
            if (r_s1_last) begin
                n_offset_seen = '0;
                n_onset_seen  = '0;
            end else begin
                n_offset_seen = w_offset_acc;
                n_onset_seen  = w_onset_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_seen <= '0;
            r_onset_seen  <= '0;
        end else begin
            r_offset_seen <= n_offset_seen;
            r_onset_seen  <= n_onset_seen;
        end
    end

    // result register: loads on a last word, empties when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_s1_fire && r_s1_last) begin
            n_out_valid = 1'b1;
        end else if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_last) begin
            r_feasible <= (w_conflict == '0);
            r_conflict <= w_conflict;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.feasible          = r_feasible;
    assign o_out.conflict_patterns = r_conflict;

    // checks
    `RFC_ASSERT_IMPL(a_feasible_matches_mask, i_clk, i_rst_n, r_out_valid,
        r_feasible == (r_conflict == '0), "feasible flag disagrees with conflict mask")
    `RFC_ASSERT_NEXT(a_sticky_cleared_after_last, i_clk, i_rst_n, w_s1_fire && r_s1_last,
        r_offset_seen == '0 && r_onset_seen == '0, "sticky bits not cleared after last word")
    `RFC_ASSERT_NEXT(a_result_after_last, i_clk, i_rst_n, w_s1_fire && r_s1_last,
        r_out_valid, "last word did not produce a result")
    `RFC_ASSERT_IMPL(a_stall_only_on_full_output, i_clk, i_rst_n, !i_in.ready,
        r_s1_valid && r_s1_last && r_out_valid && !o_out.ready,
        "input stalled without a blocked last word")

endmodule

// ----- rtl/core/rfc_pattern_scan.sv -----
// combinational scan of one word: which divisor patterns occur with target 0 / 1
// depends on rfc_pkg
module rfc_pattern_scan #(
    parameter int WORD_BITS = 64
) (
    input  logic [WORD_BITS-1:0]                      i_target,
    input  logic [rfc_pkg::DIVISOR_MAX-1:0][WORD_BITS-1:0] i_divisor,
    input  logic [rfc_pkg::DIV_COUNT_BITS-1:0]        i_divisor_count,
    output rfc_pkg::t_seen                            o_seen
);
    import rfc_pkg::*;

    logic [DIVISOR_MAX-1:0][WORD_BITS-1:0]   w_div;
    logic [PATTERN_COUNT-1:0][WORD_BITS-1:0] w_term;

    // unused divisors read as all ones; counts above four keep all four
    always_comb begin
        for (int b = 0; b < DIVISOR_MAX; b++) begin
            w_div[b] = (i_divisor_count > DIV_COUNT_BITS'(b)) ? i_divisor[b] : '1;
        end
    end

    // bit b of pattern h selects the inverted divisor b
    always_comb begin
        for (int h = 0; h < PATTERN_COUNT; h++) begin
            w_term[h] = '1;
            for (int b = 0; b < DIVISOR_MAX; b++) begin
                if (h[b]) begin
                    w_term[h] = w_term[h] & ~w_div[b];
                end else begin
                    w_term[h] = w_term[h] & w_div[b];
                end
            end
            o_seen.offset[h] = |(w_term[h] & ~i_target);
            o_seen.onset[h]  = |(w_term[h] & i_target);
        end
    end

endmodule

// ----- verif/tb_resub_feasibility_check.sv -----
// self-checking testbench for resub_feasibility_check: random and directed truth tables
// depends on rfc_pkg, rfc_in_if, rfc_out_if and the resub_feasibility_check rtl
module tb_resub_feasibility_check;
    timeunit 1ns;
    timeprecision 1ps;
    import rfc_pkg::*;

    localparam int WORD_BITS    = 64;
    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either channel
    localparam int DRAIN_CYCLES = 6;     // word register + result register, with margin
    localparam int RANDOM_ITEMS = 1500;

    typedef logic [FIELD_BITS-1:0] t_word;

    // one input transaction as seen on the word channel
    typedef struct packed {
        t_word target;
        t_word div0;
        t_word div1;
        t_word div2;
        t_word div3;
        logic  last;
    } t_table_word;

    // one result transaction
    typedef struct packed {
        logic          feasible;
        t_pattern_mask conflicts;
    } t_verdict;

    // how a random truth table is built
    typedef enum int {
        STYLE_NOISE,  // single word, random content, random last flag
        STYLE_FUNC,   // target is a function of the divisors in use
        STYLE_FLIP,   // as above with one target bit flipped
        STYLE_WIDE    // target depends on all four divisors whatever the count
    } t_table_style;

    // receiver back-pressure patterns
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC,
        RDY_SPARSE
    } t_ready_mode;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [DIV_COUNT_BITS-1:0] i_cfg_wdata;

    rfc_in_if  word_if ();
    rfc_out_if verdict_if ();

    resub_feasibility_check #(
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (word_if),
        .o_out       (verdict_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------

    t_table_word word_queue[$];     // words waiting for the driver
    t_verdict    verdict_queue[$];  // predicted results, oldest first

    // predictor copy of the block: divisor count register and sticky vectors
    logic [DIV_COUNT_BITS-1:0] active_divisors = RESET_DIVISOR_COUNT;
    t_pattern_mask             zero_hits = '0;
    t_pattern_mask             one_hits  = '0;

    int  mismatch_count = 0;
    int  stall_cycles   = 0;
    bit  word_taken     = 1'b0;  // word transaction completed at the last rising edge
    bit  any_moved;
    int  plan_divisors  = DIVISOR_MAX;  // divisors in use, as seen by the stimulus side

    // driver burst / gap bookkeeping
    int  burst_left = 1;
    int  gap_left   = 0;

    // receiver pattern bookkeeping
    t_ready_mode ready_mode = RDY_ALWAYS;
    int          mode_left  = 0;
    int          stall_phase = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // fold one accepted word into the sticky vectors; a last word closes the
    // truth table, queues the verdict and clears the vectors
    function automatic void fold_truth_word(input t_table_word w);
        t_word    mask;
        t_word    t_on;
        t_word    t_off;
        t_word    term;
        t_word    d [DIVISOR_MAX];
        int       used;
        t_verdict v;
        mask  = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);
        t_on  = w.target & mask;
        t_off = ~w.target & mask;
        // counts above four behave as four
        used  = (active_divisors > DIVISOR_MAX) ? DIVISOR_MAX : int'(active_divisors);
        // unused divisors read as all ones
        d[0] = (used > 0) ? w.div0 : '1;
        d[1] = (used > 1) ? w.div1 : '1;
        d[2] = (used > 2) ? w.div2 : '1;
        d[3] = (used > 3) ? w.div3 : '1;
        for (int h = 0; h < PATTERN_COUNT; h++) begin
            term = '1;
            // bit b of the pattern index is the inverted divisor value
            for (int b = 0; b < DIVISOR_MAX; b++) begin
                term &= ((h >> b) & 1) ? ~d[b] : d[b];
            end
            if ((term & t_off) != '0) zero_hits[h] = 1'b1;
            if ((term & t_on) != '0) one_hits[h] = 1'b1;
        end
        if (w.last) begin
            v.conflicts = zero_hits & one_hits;
            v.feasible  = (v.conflicts == '0);
            verdict_queue = {verdict_queue, v};
            zero_hits = '0;
            one_hits  = '0;
        end
    endfunction

    function automatic void report_mismatch(input string what, input t_verdict want,
                                            input t_verdict got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch, %s: expected feasible=%0b conflicts=%04h,", what,
                     want.feasible, want.conflicts,
                     " got feasible=%0b conflicts=%04h", got.feasible, got.conflicts);
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: samples both channels and the config port at the rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_verdict    got;
        t_table_word seen;
        any_moved  = 1'b0;
        word_taken = 1'b0;
        if (!i_rst_n) begin
            // synchronous reset of the predictor copy
            active_divisors = RESET_DIVISOR_COUNT;
            zero_hits       = '0;
            one_hits        = '0;
        end else begin
            if (i_cfg_we) active_divisors = i_cfg_wdata;
            // result side first; a word accepted now cannot have its result yet
            if (verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1) begin
                any_moved     = 1'b1;
                got.feasible  = verdict_if.feasible;
                got.conflicts = verdict_if.conflict_patterns;
                if (verdict_queue.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, got);
                end else begin
                    if (got.feasible !== verdict_queue[0].feasible ||
                        got.conflicts !== verdict_queue[0].conflicts) begin
                        report_mismatch("field compare", verdict_queue[0], got);
                    end
                    void'(verdict_queue.pop_front());
                end
            end
            // word side: predict from what actually sat on the bus
            if (word_if.valid === 1'b1 && word_if.ready === 1'b1) begin
                any_moved   = 1'b1;
                word_taken  = 1'b1;
                seen.target = word_if.target_word;
                seen.div0   = word_if.first_divisor_word;
                seen.div1   = word_if.second_divisor_word;
                seen.div2   = word_if.third_divisor_word;
                seen.div3   = word_if.fourth_divisor_word;
                seen.last   = word_if.last_word;
                fold_truth_word(seen);
            end
        end
        stall_cycles = any_moved ? 0 : stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps, changes at the falling edge
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        t_table_word w;
        // hold the current word until the block takes it
        if (i_rst_n && !(word_if.valid === 1'b1 && !word_taken)) begin
            if (gap_left > 0) begin
                word_if.valid <= 1'b0;
                gap_left--;
            end else if (word_queue.size() != 0) begin
                w = word_queue.pop_front();
                word_if.target_word         <= w.target;
                word_if.first_divisor_word  <= w.div0;
                word_if.second_divisor_word <= w.div1;
                word_if.third_divisor_word  <= w.div2;
                word_if.fourth_divisor_word <= w.div3;
                word_if.last_word           <= w.last;
                word_if.valid               <= 1'b1;
                if (burst_left <= 1) begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                word_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready pattern whose mode is redrawn at random
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = t_ready_mode'($urandom_range(RDY_ALWAYS, RDY_SPARSE));
            mode_left  = $urandom_range(32, 400);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS:   verdict_if.ready <= 1'b1;
            RDY_COIN:     verdict_if.ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: verdict_if.ready <= ((stall_phase % 5) < 2);
            default:      verdict_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        stall_phase++;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // divisor word biased toward the interesting shapes
    function automatic t_word pick_divisor(input t_word other);
        t_word d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            2:       d = other;
            3:       d = ~other;
            4:       d = rand_word() & rand_word();
            5:       d = rand_word() | rand_word();
            default: d = rand_word();
        endcase
        return d;
    endfunction

    // target word that follows function f of the first 'used' divisors
    function automatic t_word target_of(input t_pattern_mask f, input t_table_word w,
                                        input int used);
        t_word      t;
        logic [3:0] h;
        for (int i = 0; i < FIELD_BITS; i++) begin
            h = '0;
            if (used > 0) h[0] = ~w.div0[i];
            if (used > 1) h[1] = ~w.div1[i];
            if (used > 2) h[2] = ~w.div2[i];
            if (used > 3) h[3] = ~w.div3[i];
            t[i] = f[h];
        end
        return t;
    endfunction

    task automatic queue_word(input t_word t, input t_word d0, input t_word d1,
                              input t_word d2, input t_word d3, input logic last);
        t_table_word w;
        w.target = t;
        w.div0   = d0;
        w.div1   = d1;
        w.div2   = d2;
        w.div3   = d3;
        w.last   = last;
        word_queue = {word_queue, w};
    endtask

    // one random truth table; returns the number of words queued
    task automatic queue_table(input t_table_style style, output int words);
        t_table_word   w;
        t_pattern_mask f;
        int            used;
        int            len;
        int            flip_at;
        t_word         prev;
        if (style == STYLE_NOISE) begin
            queue_word(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                       ($urandom_range(0, 3) == 0));
            words = 1;
        end else begin
            f    = t_pattern_mask'($urandom);
            used = (style == STYLE_WIDE) ? DIVISOR_MAX : plan_divisors;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
            prev = rand_word();
            for (int k = 0; k < len; k++) begin
                w.div0   = pick_divisor(prev);
                w.div1   = pick_divisor(w.div0);
                w.div2   = pick_divisor(w.div1);
                w.div3   = pick_divisor(w.div2);
                prev     = w.div3;
                w.target = target_of(f, w, used);
                if (style == STYLE_FLIP && k == len - 1) begin
                    flip_at  = $urandom_range(0, FIELD_BITS - 1);
                    w.target = w.target ^ (t_word'(1) << flip_at);
                end
                w.last = (k == len - 1);
                word_queue = {word_queue, w};
            end
            words = len;
        end
    endtask

    // wait until every word is taken and every verdict has come, then let
    // the pipeline drain non-last words before touching the register
    task automatic wait_quiet();
        while (word_queue.size() != 0 || word_if.valid === 1'b1 ||
               verdict_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divisor_count(input logic [DIV_COUNT_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        plan_divisors = (value > DIVISOR_MAX) ? DIVISOR_MAX : int'(value);
    endtask

    // ------------------------------------------------------------------
    // watchdog: nothing moving on either channel for too long
    // ------------------------------------------------------------------

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        t_word                     a;
        t_word                     b;
        t_word                     c;
        t_word                     e;
        int                        sent;
        int                        phase_goal;
        int                        phase_sent;
        int                        words;
        int                        pick;
        t_table_style              style;
        logic [DIV_COUNT_BITS-1:0] phase_counts [8];

        // every input known from time zero
        i_rst_n                     = 1'b0;
        i_cfg_we                    = 1'b0;
        i_cfg_wdata                 = '0;
        word_if.valid               = 1'b0;
        word_if.target_word         = '0;
        word_if.first_divisor_word  = '0;
        word_if.second_divisor_word = '0;
        word_if.third_divisor_word  = '0;
        word_if.fourth_divisor_word = '0;
        word_if.last_word           = 1'b0;
        verdict_if.ready            = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, at the reset divisor count of four
        a = 64'haaaa_aaaa_aaaa_aaaa;
        b = 64'hcccc_cccc_cccc_cccc;
        c = 64'hf0f0_f0f0_f0f0_f0f0;
        e = 64'hff00_ff00_ff00_ff00;
        queue_word('0, '0, '0, '0, '0, 1'b1);                      // all zeros
        queue_word('1, '1, '1, '1, '1, 1'b1);                      // all ones
        queue_word('1, '0, '0, '0, '0, 1'b1);
        queue_word('0, '1, '1, '1, '1, 1'b1);
        queue_word(64'h5555_5555_5555_5555, '0, '0, '0, '0, 1'b1); // one pattern, both values
        queue_word(a, a, b, c, e, 1'b1);                           // target equals a divisor
        queue_word(a ^ b ^ c ^ e, a, b, c, e, 1'b1);               // parity of all four
        // multi-word table whose words disagree
        queue_word(a, a, b, c, e, 1'b0);
        queue_word(~b, a, b, c, e, 1'b0);
        queue_word(c, a, b, c, e, 1'b1);
        // multi-word table that stays consistent
        queue_word(a & b, a, b, c, e, 1'b0);
        queue_word(c & e, c, e, a, b, 1'b0);
        queue_word(b & a, b, a, e, c, 1'b1);
        // top and bottom bits alone
        queue_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '1, '1, '1, 1'b1);
        queue_word(~64'h1, '0, '0, '0, '0, 1'b1);
        wait_quiet();

        // no divisors: the target has to be constant
        write_divisor_count(3'd0);
        queue_word('1, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0);
        queue_word('1, rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
        queue_word('0, rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
        queue_word(64'h1, rand_word(), rand_word(), rand_word(), rand_word(), 1'b1);
        wait_quiet();

        // one divisor: only the first divisor counts
        write_divisor_count(3'd1);
        a = rand_word();
        queue_word(a, a, rand_word(), rand_word(), rand_word(), 1'b1);
        b = rand_word();
        queue_word(b, rand_word(), b, rand_word(), rand_word(), 1'b1);
        wait_quiet();

        // highest register value acts as four
        write_divisor_count(3'd7);
        a = rand_word();
        b = rand_word();
        c = rand_word();
        e = rand_word();
        queue_word(a ^ b ^ c ^ e, a, b, c, e, 1'b1);
        queue_word(a & c, a, b, c, e, 1'b1);
        wait_quiet();

        // random phases: first every register value once, then random
        phase_counts = '{3'd2, 3'd3, 3'd5, 3'd6, 3'd0, 3'd4, 3'd7, 3'd1};
        sent = 0;
        for (int p = 0; sent < RANDOM_ITEMS; p++) begin
            if (p < 8) begin
                write_divisor_count(phase_counts[p]);
            end else begin
                write_divisor_count(DIV_COUNT_BITS'($urandom_range(0, 7)));
            end
            phase_goal = $urandom_range(80, 160);
            phase_sent = 0;
            while (phase_sent < phase_goal) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)       style = STYLE_NOISE;
                else if (pick < 6)  style = STYLE_FUNC;
                else if (pick < 8)  style = STYLE_FLIP;
                else                style = STYLE_WIDE;
                queue_table(style, words);
                phase_sent += words;
            end
            sent += phase_sent;
            // the sender pauses here until every verdict of the phase is in
            wait_quiet();
        end

        wait_quiet();
        if (mismatch_count == 0 && verdict_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- resub_feasibility_check.f -----
+incdir+rtl/core
rtl/core/rfc_pkg.sv
rtl/core/rfc_in_if.sv
rtl/core/rfc_out_if.sv
rtl/core/rfc_pattern_scan.sv
rtl/core/resub_feasibility_check.sv
verif/tb_resub_feasibility_check.sv
